### hw/rtl/lcdnws_pkg.sv
// ----------------------------------------------------------------------------
// lcdnws_pkg
// Shared types, register indexes and the init program of the character LCD
// nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdnws_pkg;

    // Request kinds
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_DATA = 2'd1;
    localparam logic [1:0] ACT_POS  = 2'd2;
    localparam logic [1:0] ACT_INIT = 2'd3;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_BUSY   = 1'b0;
    localparam logic REG_STROBE = 1'b1;

    localparam logic [15:0] BUSY_US_RST   = 16'd2000;
    localparam logic [7:0]  STROBE_US_RST = 8'd1;

    localparam int QUEUE_DEPTH = 2;

    localparam int          APB_AW        = 3;
    localparam int          APB_DW        = 32;
    localparam logic [3:0]  INIT_LAST_SEG = 4'd9;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       line_select;
        logic [5:0] column;
    } t_req;

    typedef struct packed {
        logic [3:0]  data_nibble;
        logic        reg_select;
        logic        read_write;
        logic        enable;
        logic [15:0] hold_us;
        logic        last_step;
    } t_step;

    // Classified request as queued between front and back
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One segment of a request: a plain wait or a whole byte write
    typedef struct packed {
        logic        is_wait;
        logic [15:0] hold;
        logic [7:0]  byte_val;
    } t_seg;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_bstate;

    // Power-on init program
    function automatic t_seg init_seg(input logic [3:0] idx);
        t_seg s;
        s = '{is_wait: 1'b0, hold: 16'd0, byte_val: 8'h06};
        unique case (idx)
            4'd0:    s = '{is_wait: 1'b1, hold: 16'd15000, byte_val: 8'h00};
            4'd1:    s.byte_val = 8'h20;
            4'd2:    s = '{is_wait: 1'b1, hold: 16'd5000, byte_val: 8'h00};
            4'd3:    s.byte_val = 8'h20;
            4'd4:    s = '{is_wait: 1'b1, hold: 16'd100, byte_val: 8'h00};
            4'd5:    s.byte_val = 8'h20;
            4'd6:    s.byte_val = 8'h28;
            4'd7:    s.byte_val = 8'h0C;
            4'd8:    s.byte_val = 8'h01;
            default: s.byte_val = 8'h06;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/lcdnws_front.sv
// ----------------------------------------------------------------------------
// lcdnws_front
// Accepts requests, turns each into a byte job or an init job and hands it
// to the queue through one register slot.
// ----------------------------------------------------------------------------
module lcdnws_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lcdnws_pkg::t_req  i_req,
    input  logic              i_full,
    output logic              o_push,
    output lcdnws_pkg::t_job  o_job
);
    import lcdnws_pkg::*;

    logic r_vld, n_vld;
    t_job r_job, n_job;
    t_job cls;

    always_comb begin
        cls = '{is_init: 1'b0, rs: 1'b0, byte_val: i_req.data_byte};
        unique case (i_req.action)
            ACT_CMD:  cls.rs = 1'b0;
            ACT_DATA: cls.rs = 1'b1;
            // line adds 0x40 and the column stays below it, so the sum is a concat
            ACT_POS:  cls.byte_val = {1'b1, i_req.line_select, i_req.column};
            default:  cls.is_init = 1'b1;
        endcase
    end

    assign o_push      = r_vld && !i_full;
    assign o_req_ready = !r_vld || !i_full;
    assign o_job       = r_job;

    always_comb begin
        n_vld = r_vld && i_full;
        n_job = r_job;
        if (i_req_valid && o_req_ready) begin
            n_vld = 1'b1;
            n_job = cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_job <= n_job;
    end

endmodule

### hw/rtl/lcdnws_queue.sv
// ----------------------------------------------------------------------------
// lcdnws_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lcdnws_queue #(
    parameter int DEPTH = lcdnws_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcdnws_pkg::t_job    i_job,
    input  logic                i_pop,
    output lcdnws_pkg::t_job    o_job,
    output lcdnws_pkg::t_q_stat o_stat
);
    import lcdnws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_job        = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### hw/rtl/lcdnws_back.sv
// ----------------------------------------------------------------------------
// lcdnws_back
// Walks one job through its segments and pin steps, keeps the pin word and
// holds each step in an output register until it is taken.
// ----------------------------------------------------------------------------
module lcdnws_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcdnws_pkg::t_q_stat i_stat,
    input  lcdnws_pkg::t_job    i_job,
    output logic                o_pop,
    input  logic [15:0]         i_busy_us,
    input  logic [7:0]          i_strobe_us,
    output logic                o_step_valid,
    input  logic                i_step_ready,
    output lcdnws_pkg::t_step   o_step
);
    import lcdnws_pkg::*;

    localparam logic [2:0] SUB_WAIT = 3'd0;
    localparam logic [2:0] SUB_HI   = 3'd1;
    localparam logic [2:0] SUB_HI_E = 3'd2;
    localparam logic [2:0] SUB_LO   = 3'd4;
    localparam logic [2:0] SUB_LO_E = 3'd5;
    localparam logic [2:0] SUB_END  = 3'd6;

    t_bstate    r_state, n_state;
    t_job       r_job, n_job;
    logic [3:0] r_seg, n_seg;
    logic [2:0] r_sub, n_sub;
    logic [5:0] r_pin, n_pin;
    t_step      r_out, n_out;
    logic       r_out_vld, n_out_vld;

    t_seg        seg;
    logic        rs;
    logic        final_seg;
    logic [3:0]  nib;
    logic [5:0]  pin;
    logic [15:0] hold;
    logic        last;

    assign o_step_valid = r_out_vld;
    assign o_step       = r_out;

    always_comb begin
        seg       = r_job.is_init
                  ? init_seg(r_seg)
                  : t_seg'{is_wait: 1'b0, hold: 16'd0, byte_val: r_job.byte_val};
        rs        = r_job.is_init ? 1'b0 : r_job.rs;
        final_seg = !r_job.is_init || (r_seg == INIT_LAST_SEG);
        nib       = (r_sub < SUB_LO) ? seg.byte_val[7:4] : seg.byte_val[3:0];
        pin       = r_pin;
        hold      = 16'd0;
        last      = 1'b0;

        n_state   = r_state;
        n_job     = r_job;
        n_seg     = r_seg;
        n_sub     = r_sub;
        n_pin     = r_pin;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_step_ready;
        o_pop     = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_seg   = '0;
                    n_sub   = SUB_WAIT;
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (!r_out_vld || i_step_ready) begin
                    if (seg.is_wait) begin
                        // init opens by dropping E
                        if (r_seg == '0) begin
                            pin[1] = 1'b0;
                        end
                        hold  = seg.hold;
                        n_seg = r_seg + 1'b1;
                    end else begin
                        unique case (r_sub)
                            SUB_WAIT: hold = i_busy_us;
                            SUB_HI, SUB_LO: begin
                                pin  = {nib, 1'b0, rs};
                                hold = {8'd0, i_strobe_us};
                            end
                            SUB_HI_E, SUB_LO_E: begin
                                pin[1] = 1'b1;
                                hold   = {8'd0, i_strobe_us};
                            end
                            default: begin
                                pin[1] = 1'b0;
                                hold   = 16'd0;
                            end
                        endcase
                        if (r_sub == SUB_END) begin
                            n_sub = SUB_WAIT;
                            n_seg = r_seg + 1'b1;
                            last  = final_seg;
                        end else begin
                            n_sub = r_sub + 1'b1;
                        end
                    end
                    if (last) begin
                        n_state = B_IDLE;
                    end
                    n_pin             = pin;
                    n_out.data_nibble = pin[5:2];
                    n_out.reg_select  = pin[0];
                    n_out.read_write  = 1'b0;
                    n_out.enable      = pin[1];
                    n_out.hold_us     = hold;
                    n_out.last_step   = last;
                    n_out_vld         = 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_pin     <= '0;
            r_out_vld <= 1'b0;
            r_seg     <= '0;
            r_sub     <= SUB_WAIT;
        end else begin
            r_state   <= n_state;
            r_pin     <= n_pin;
            r_out_vld <= n_out_vld;
            r_seg     <= n_seg;
            r_sub     <= n_sub;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

### hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Turns LCD requests into timed 4-bit bus pin steps, with fixed init waits and register-set busy and strobe times.
// ----------------------------------------------------------------------------
// A request passes the front slot, the queue, the job and output registers of
// the back before its first pin step shows. Throughput: one step a cycle when
// steps are taken; the back loads a request only after the last one has ended.
// Reset: pins low, queue empty, busy wait 2000 us, strobe 1 us.
module char_lcd_nibble_write_sequencer_unit #(
    parameter int QUEUE_DEPTH = lcdnws_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  lcdnws_pkg::t_req                i_req,
    output logic                            o_step_valid,
    input  logic                            i_step_ready,
    output lcdnws_pkg::t_step               o_step,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcdnws_pkg::APB_AW-1:0]   paddr,
    input  logic [lcdnws_pkg::APB_DW-1:0]   pwdata,
    output logic [lcdnws_pkg::APB_DW-1:0]   prdata,
    output logic                            pready
);
    import lcdnws_pkg::*;

    logic [15:0] r_busy_us;
    logic [7:0]  r_strobe_us;
    logic        cfg_wr;

    logic    push, pop;
    t_job    f_job, q_job;
    t_q_stat q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_BUSY: prdata = {16'd0, r_busy_us};
            default:  prdata = {24'd0, r_strobe_us};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_us   <= BUSY_US_RST;
            r_strobe_us <= STROBE_US_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BUSY) begin
                r_busy_us <= pwdata[15:0];
            end else begin
                r_strobe_us <= pwdata[7:0];
            end
        end
    end

    lcdnws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_full      (q_stat.full),
        .o_push      (push),
        .o_job       (f_job)
    );

    lcdnws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    lcdnws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stat       (q_stat),
        .i_job        (q_job),
        .o_pop        (pop),
        .i_busy_us    (r_busy_us),
        .i_strobe_us  (r_strobe_us),
        .o_step_valid (o_step_valid),
        .i_step_ready (i_step_ready),
        .o_step       (o_step)
    );

    // A request never ends with E high
    a_no_last_e_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step_valid && o_step.enable |-> !o_step.last_step)
        else $error("request ended with E high");

    // E-high steps carry the strobe time
    a_e_high_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step_valid && o_step.enable |-> o_step.hold_us == {8'd0, r_strobe_us})
        else $error("E-high step hold differs from strobe time");

    // Queue cannot be full and empty at once
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // Nothing is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");

endmodule

### dv/lcdnws_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcdnws_step_checker
// Watches the request, step and register channels of the LCD nibble write
// sequencer. Expands every accepted request into its expected pin steps and
// compares each accepted step, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module lcdnws_step_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  lcdnws_pkg::t_req                i_req,
    input  logic                            i_step_valid,
    input  logic                            i_step_ready,
    input  lcdnws_pkg::t_step               i_step,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [lcdnws_pkg::APB_AW-1:0]   i_paddr,
    input  logic [lcdnws_pkg::APB_DW-1:0]   i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lcdnws_pkg::*;

    logic [15:0] busy_us;
    logic [7:0]  strobe_us;
    logic [5:0]  pin_state;   // nibble in 5..2, E in 1, RS in 0
    t_step       step_expect_q[$];
    t_step       step_want;
    int          mismatch_cnt = 0;
    int          step_idx;

    assign o_fail_count = mismatch_cnt;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("step %0d: %s is %0h, expected %0h", step_idx, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic push_step(input logic [15:0] hold);
        t_step s;
        s.data_nibble = pin_state[5:2];
        s.reg_select  = pin_state[0];
        s.read_write  = 1'b0;
        s.enable      = pin_state[1];
        s.hold_us     = hold;
        s.last_step   = 1'b0;
        step_expect_q.push_back(s);
    endtask

    // Setup with E low, raise E, drop E
    task automatic send_nibble(input logic [3:0] nib, input logic rs);
        pin_state = {nib, 1'b0, rs};
        push_step({8'd0, strobe_us});
        pin_state[1] = 1'b1;
        push_step({8'd0, strobe_us});
        pin_state[1] = 1'b0;
        push_step(16'd0);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic rs);
        push_step(busy_us);
        send_nibble(b[7:4], rs);
        send_nibble(b[3:0], rs);
    endtask

    task automatic expand_request(input t_req r);
        t_step      tail;
        logic [7:0] addr_cmd;
        case (r.action)
            ACT_CMD: begin
                send_byte(r.data_byte, 1'b0);
            end
            ACT_DATA: begin
                send_byte(r.data_byte, 1'b1);
            end
            ACT_POS: begin
                addr_cmd = 8'h80 | (((r.line_select ? 8'h40 : 8'h00)
                                     + {2'b00, r.column}) & 8'h7F);
                send_byte(addr_cmd, 1'b0);
            end
            default: begin
                // power-on init: drop E, then the fixed wait and command list
                pin_state[1] = 1'b0;
                push_step(16'd15000);
                send_byte(8'h20, 1'b0);
                push_step(16'd5000);
                send_byte(8'h20, 1'b0);
                push_step(16'd100);
                send_byte(8'h20, 1'b0);
                send_byte(8'h28, 1'b0);
                send_byte(8'h0C, 1'b0);
                send_byte(8'h01, 1'b0);
                send_byte(8'h06, 1'b0);
            end
        endcase
        tail = step_expect_q.pop_back();
        tail.last_step = 1'b1;
        step_expect_q.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            busy_us   = BUSY_US_RST;
            strobe_us = STROBE_US_RST;
            pin_state = 6'd0;
            step_expect_q.delete();
            step_idx  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_BUSY) begin
                    busy_us = i_pwdata[15:0];
                end else begin
                    strobe_us = i_pwdata[7:0];
                end
            end
            if (i_req_valid && i_req_ready) begin
                expand_request(i_req);
            end
            if (i_step_valid && i_step_ready) begin
                if (step_expect_q.size() == 0) begin
                    report_mismatch("unexpected step", 16'd0, 16'd0);
                end else begin
                    step_want = step_expect_q.pop_front();
                    if (i_step.data_nibble !== step_want.data_nibble)
                        report_mismatch("data_nibble", 16'(i_step.data_nibble),
                                        16'(step_want.data_nibble));
                    if (i_step.reg_select !== step_want.reg_select)
                        report_mismatch("reg_select", 16'(i_step.reg_select),
                                        16'(step_want.reg_select));
                    if (i_step.read_write !== step_want.read_write)
                        report_mismatch("read_write", 16'(i_step.read_write),
                                        16'(step_want.read_write));
                    if (i_step.enable !== step_want.enable)
                        report_mismatch("enable", 16'(i_step.enable),
                                        16'(step_want.enable));
                    if (i_step.hold_us !== step_want.hold_us)
                        report_mismatch("hold_us", i_step.hold_us, step_want.hold_us);
                    if (i_step.last_step !== step_want.last_step)
                        report_mismatch("last_step", 16'(i_step.last_step),
                                        16'(step_want.last_step));
                end
                step_idx++;
            end
        end
        o_pending <= step_expect_q.size();
    end

endmodule

### dv/tb_char_lcd_nibble_write_sequencer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer_unit
// Drives command, data, position and init requests through the sequencer
// under several timing register settings, with random idling on both sides;
// the checker beside the block predicts and compares every pin step.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer_unit;
    import lcdnws_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 65;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_req_valid = 1'b0;
    logic                o_req_ready;
    t_req                i_req = '0;
    logic                o_step_valid;
    logic                i_step_ready = 1'b0;
    t_step               o_step;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int   fail_count;
    int   steps_pending;
    logic calm = 1'b0;
    int   ready_hold = 0;
    int   idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    char_lcd_nibble_write_sequencer_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_step_valid (o_step_valid),
        .i_step_ready (i_step_ready),
        .o_step       (o_step),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    lcdnws_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_step_valid (o_step_valid),
        .i_step_ready (i_step_ready),
        .i_step       (o_step),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (steps_pending)
    );

    // Step receiver: drop ready at random, in bursts, none once calm
    always @(posedge i_clk) begin
        if (calm) begin
            i_step_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_step_ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_step_ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 2);
        end else begin
            i_step_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_step_valid && i_step_ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_char_lcd_nibble_write_sequencer_unit failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one item, holding valid and payload until it is accepted
    task automatic send_req(input t_req r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    // Hold off the sender until every expected step has come
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (steps_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        t_req rq;
        int   pick;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset timing
        send_req('{action: ACT_CMD,  data_byte: 8'h00, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_CMD,  data_byte: 8'hFF, line_select: 1'b1, column: 6'd63});
        send_req('{action: ACT_DATA, data_byte: 8'h00, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_DATA, data_byte: 8'hFF, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_DATA, data_byte: 8'hA5, line_select: 1'b1, column: 6'h2A});
        send_req('{action: ACT_DATA, data_byte: 8'h5A, line_select: 1'b0, column: 6'h15});
        send_req('{action: ACT_POS,  data_byte: 8'h00, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_POS,  data_byte: 8'hFF, line_select: 1'b0, column: 6'd63});
        send_req('{action: ACT_POS,  data_byte: 8'h00, line_select: 1'b1, column: 6'd0});
        send_req('{action: ACT_POS,  data_byte: 8'h00, line_select: 1'b1, column: 6'd63});
        send_req('{action: ACT_POS,  data_byte: 8'hC3, line_select: 1'b1, column: 6'h21});
        send_req('{action: ACT_INIT, data_byte: 8'h00, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_CMD,  data_byte: 8'h01, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_INIT, data_byte: 8'hFF, line_select: 1'b1, column: 6'd63});
        send_req('{action: ACT_DATA, data_byte: 8'h30, line_select: 1'b0, column: 6'd0});
        send_req('{action: ACT_CMD,  data_byte: 8'h80, line_select: 1'b1, column: 6'h3F});

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    apb_write(REG_BUSY, 32'd0);
                    apb_write(REG_STROBE, 32'd0);
                end
                1: begin
                    apb_write(REG_BUSY, 32'd65535);
                    apb_write(REG_STROBE, 32'd255);
                end
                default: begin
                    apb_write(REG_BUSY, 32'($urandom_range(0, 65535)));
                    apb_write(REG_STROBE, 32'($urandom_range(0, 255)));
                end
            endcase
            if (ph == 3) calm <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == ITEMS_PER_PHASE / 2) wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 30)      rq.action = ACT_CMD;
                else if (pick < 65) rq.action = ACT_DATA;
                else if (pick < 90) rq.action = ACT_POS;
                else                rq.action = ACT_INIT;
                rq.data_byte   = 8'($urandom_range(0, 255));
                rq.line_select = 1'($urandom_range(0, 1));
                rq.column      = 6'($urandom_range(0, 63));
                send_req(rq);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_char_lcd_nibble_write_sequencer_unit passed");
        end else begin
            $display("tb_char_lcd_nibble_write_sequencer_unit failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/lcdnws_pkg.sv
hw/rtl/lcdnws_front.sv
hw/rtl/lcdnws_queue.sv
hw/rtl/lcdnws_back.sv
hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
dv/lcdnws_step_checker.sv
dv/tb_char_lcd_nibble_write_sequencer_unit.sv
